FILE: sv/tti_pkg.sv
// Shared types and constants of the thermistor table interpolator.
// Holds field widths, result codes and the controller/datapath command and status structs.
// No dependencies.
package tti_pkg;

  localparam int TEMP_W   = 16;
  localparam int IN_ADC_W = 16;
  localparam int IDX_IN_W = 6;
  localparam int COUNT_W  = 7;
  localparam int HOW_W    = 3;

  localparam logic signed [TEMP_W-1:0] FALLBACK_TEMP = 16'sd300;

  typedef enum logic [HOW_W-1:0] {
    HOW_CLAMP_LO,
    HOW_CLAMP_HI,
    HOW_EXACT,
    HOW_INTERP,
    HOW_FALLBACK
  } found_how_e;

  typedef enum logic [2:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_MID,
    ADDR_UP,
    ADDR_DN
  } addr_sel_e;

  typedef enum logic [1:0] {
    RES_FALLBACK,
    RES_MEM,
    RES_BASE,
    RES_SUM
  } res_src_e;

  typedef struct packed {
    logic       wr_en;
    logic       load;
    addr_sel_e  addr_sel;
    logic       search_init;
    logic       search_step;
    logic       cap_up;
    logic       cap_dn;
    logic       div_start;
    logic       res_load;
    res_src_e   res_src;
    found_how_e res_how;
    logic       out_load;
  } tti_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic le_first;
    logic ge_last;
    logic search_end;
    logic cmp_gt;
    logic cmp_lt;
    logic dv_zero;
    logic div_done;
  } tti_sts_t;

endpackage

FILE: sv/tti_if.sv
// Handshake channels of the thermistor table interpolator: input items,
// result items and the configuration write channel.
// Depends on tti_pkg for the field widths.
interface tti_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [tti_pkg::IDX_IN_W-1:0]         entry_index;
  logic [tti_pkg::IN_ADC_W-1:0]         entry_adc;
  logic signed [tti_pkg::TEMP_W-1:0]    entry_temperature;
  logic [tti_pkg::IN_ADC_W-1:0]         reading;

  modport source (output valid, op, entry_index, entry_adc, entry_temperature, reading,
                  input ready);
  modport sink (input valid, op, entry_index, entry_adc, entry_temperature, reading,
                output ready);
endinterface

interface tti_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tti_pkg::TEMP_W-1:0]    temperature;
  logic [tti_pkg::HOW_W-1:0]            found_how;

  modport source (output valid, temperature, found_how, input ready);
  modport sink (input valid, temperature, found_how, output ready);
endinterface

interface tti_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tti_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

FILE: sv/tti_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Used by tti_dp for the interpolation step; no package dependency.
module tti_div #(
  parameter int N_W = 32,
  parameter int D_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W-1:0]   dvs_q, dvs_d;
  logic [D_W:0]     trial;
  logic             last_step;

  assign last_step = busy_q && (cnt_q == CNT_W'(N_W - 1));
  assign trial     = {rem_q, quo_q[N_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = D_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[N_W-2:0], 1'b1};
      end else begin
        rem_d = trial[D_W-1:0];
        quo_d = {quo_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = last_step;
  assign quotient_o = quo_q;

endmodule

FILE: sv/tti_dp.sv
// Datapath of the thermistor table interpolator: table memory, count register,
// search pointers, multiplier, divider and result/output registers.
// Depends on tti_pkg and tti_div.
module tti_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADC_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tti_pkg::tti_cmd_t                   cmd_i,
  output tti_pkg::tti_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [tti_pkg::COUNT_W-1:0]         cfg_data_i,
  input  logic [tti_pkg::IDX_IN_W-1:0]        entry_index_i,
  input  logic [tti_pkg::IN_ADC_W-1:0]        entry_adc_i,
  input  logic signed [tti_pkg::TEMP_W-1:0]   entry_temperature_i,
  input  logic [tti_pkg::IN_ADC_W-1:0]        reading_i,
  output logic signed [tti_pkg::TEMP_W-1:0]   temperature_o,
  output logic [tti_pkg::HOW_W-1:0]           found_how_o
);

  import tti_pkg::*;

  // Entries beyond the writable index range can never be written.
  localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << IDX_IN_W)) ? TABLE_DEPTH : (1 << IDX_IN_W);
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
  localparam int PTR_W     = CNT_W + 1;
  localparam int ADC_W     = (ADC_BITS < IN_ADC_W) ? ADC_BITS : IN_ADC_W;
  localparam int DIF_W     = ADC_W + 1;
  localparam int DT_W      = TEMP_W + 1;
  localparam int PROD_W    = DT_W + DIF_W;
  localparam int MAG_W     = TEMP_W + ADC_W;
  localparam int SUM_W     = MAG_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (TEMP_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic [ADC_W-1:0]         mem_adc [MEM_DEPTH];
  logic signed [TEMP_W-1:0] mem_tmp [MEM_DEPTH];

  logic [COUNT_W-1:0]       entry_count_q;
  logic [CNT_W-1:0]         n_q;
  logic [ADC_W-1:0]         reading_q;
  logic [ADC_W-1:0]         rd_adc_q;
  logic signed [TEMP_W-1:0] rd_tmp_q;
  logic signed [PTR_W-1:0]  lo_q, hi_q;
  logic [ADC_W-1:0]         up_adc_q;
  logic signed [TEMP_W-1:0] up_tmp_q;
  logic signed [TEMP_W-1:0] base_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DIF_W-1:0]  dv_q;
  logic                     neg_q;
  logic signed [TEMP_W-1:0] res_tmp_q;
  found_how_e               res_how_q;
  logic signed [TEMP_W-1:0] out_tmp_q;
  found_how_e               out_how_q;

  logic [CNT_W-1:0]         n_w;
  logic signed [PTR_W-1:0]  last_s;
  logic [IDX_W-1:0]         last_w;
  logic [PTR_W:0]           ptr_sum;
  logic [IDX_W-1:0]         mid_w;
  logic signed [PTR_W-1:0]  mid_s;
  logic [IDX_W-1:0]         up_w, dn_w;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_ok;
  logic signed [DT_W-1:0]   dt_w;
  logic signed [DIF_W-1:0]  dx_w, dv_w;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [DIF_W-1:0]  dv_abs;
  logic                     div_done;
  logic [MAG_W-1:0]         quo;
  logic signed [MAG_W:0]    q_s;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [TEMP_W-1:0] sat_w;
  logic signed [TEMP_W-1:0] res_tmp_d;

  // Counts above the table depth behave as the full table.
  assign n_w = (entry_count_q > COUNT_W'(MEM_DEPTH)) ? CNT_W'(MEM_DEPTH)
                                                      : entry_count_q[CNT_W-1:0];

  assign last_s  = $signed(PTR_W'(n_q)) - PTR_W'(1);
  assign last_w  = last_s[IDX_W-1:0];
  assign ptr_sum = {lo_q[PTR_W-1], lo_q} + {hi_q[PTR_W-1], hi_q};
  assign mid_w   = ptr_sum[IDX_W:1];
  assign mid_s   = $signed(PTR_W'(mid_w));

  // Neighbours that left the valid range are pulled back to the nearest edge.
  assign up_w = (lo_q > last_s) ? last_w : lo_q[IDX_W-1:0];
  assign dn_w = (hi_q < $signed(PTR_W'(0))) ? '0 : hi_q[IDX_W-1:0];

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_FIRST: rd_addr = '0;
      ADDR_LAST:  rd_addr = last_w;
      ADDR_MID:   rd_addr = mid_w;
      ADDR_UP:    rd_addr = up_w;
      ADDR_DN:    rd_addr = dn_w;
      default:    rd_addr = '0;
    endcase
  end

  assign wr_ok = cmd_i.wr_en && ({1'b0, entry_index_i} < (IDX_IN_W + 1)'(MEM_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_adc[entry_index_i[IDX_W-1:0]] <= entry_adc_i[ADC_W-1:0];
      mem_tmp[entry_index_i[IDX_W-1:0]] <= entry_temperature_i;
    end
    rd_adc_q <= mem_adc[rd_addr];
    rd_tmp_q <= mem_tmp[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  assign dt_w   = $signed({up_tmp_q[TEMP_W-1], up_tmp_q}) - $signed({rd_tmp_q[TEMP_W-1], rd_tmp_q});
  assign dx_w   = $signed({1'b0, reading_q}) - $signed({1'b0, rd_adc_q});
  assign dv_w   = $signed({1'b0, up_adc_q}) - $signed({1'b0, rd_adc_q});
  assign prod_w = dt_w * dx_w;

  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
  assign dv_abs   = dv_q[DIF_W-1] ? -dv_q : dv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q       <= n_w;
      reading_q <= reading_i[ADC_W-1:0];
    end
    if (cmd_i.search_init) begin
      lo_q <= '0;
      hi_q <= last_s;
    end else if (cmd_i.search_step) begin
      if (rd_adc_q > reading_q) begin
        hi_q <= mid_s - PTR_W'(1);
      end else begin
        lo_q <= mid_s + PTR_W'(1);
      end
    end
    if (cmd_i.cap_up) begin
      up_adc_q <= rd_adc_q;
      up_tmp_q <= rd_tmp_q;
    end
    if (cmd_i.cap_dn) begin
      base_q <= rd_tmp_q;
      prod_q <= prod_w;
      dv_q   <= dv_w;
    end
    if (cmd_i.div_start) begin
      neg_q <= prod_q[PROD_W-1] ^ dv_q[DIF_W-1];
    end
  end

  tti_div #(
    .N_W (MAG_W),
    .D_W (ADC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_abs[MAG_W-1:0]),
    .divisor_i  (dv_abs[ADC_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign q_s   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign sum_w = SUM_W'(base_q) + SUM_W'(q_s);

  always_comb begin
    if (sum_w > SAT_HI) begin
      sat_w = SAT_HI[TEMP_W-1:0];
    end else if (sum_w < SAT_LO) begin
      sat_w = SAT_LO[TEMP_W-1:0];
    end else begin
      sat_w = sum_w[TEMP_W-1:0];
    end
  end

  always_comb begin
    case (cmd_i.res_src)
      RES_FALLBACK: res_tmp_d = FALLBACK_TEMP;
      RES_MEM:      res_tmp_d = rd_tmp_q;
      RES_BASE:     res_tmp_d = base_q;
      RES_SUM:      res_tmp_d = sat_w;
      default:      res_tmp_d = FALLBACK_TEMP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_tmp_q <= res_tmp_d;
      res_how_q <= cmd_i.res_how;
    end
    if (cmd_i.out_load) begin
      out_tmp_q <= res_tmp_q;
      out_how_q <= res_how_q;
    end
  end

  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.le_first   = (rd_adc_q >= reading_q);
  assign sts_o.ge_last    = (rd_adc_q <= reading_q);
  assign sts_o.search_end = (lo_q > hi_q);
  assign sts_o.cmp_gt     = (rd_adc_q > reading_q);
  assign sts_o.cmp_lt     = (rd_adc_q < reading_q);
  assign sts_o.dv_zero    = (dv_q == '0);
  assign sts_o.div_done   = div_done;

  assign temperature_o = out_tmp_q;
  assign found_how_o   = out_how_q;

endmodule

FILE: sv/tti_ctrl.sv
// Controller of the thermistor table interpolator: sequences table writes,
// edge checks, binary search, interpolation and the output hand-off.
// Depends on tti_pkg.
module tti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  input  logic              out_ready_i,
  input  tti_pkg::tti_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output tti_pkg::tti_cmd_t cmd_o
);

  import tti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHK0,
    S_CHKN,
    S_PROBE,
    S_CMP,
    S_RDUP,
    S_RDDN,
    S_MUL,
    S_CHKDV,
    S_DIV,
    S_SUM,
    S_OUT
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  tti_cmd_t cmd;

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    cmd.addr_sel = ADDR_FIRST;
    cmd.res_src  = RES_MEM;
    cmd.res_how  = HOW_EXACT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i) begin
            cmd.load = 1'b1;
            state_d  = S_START;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_START: begin
        cmd.addr_sel = ADDR_FIRST;
        if (sts_i.n_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_FALLBACK;
          cmd.res_how  = HOW_FALLBACK;
          state_d      = S_OUT;
        end else begin
          state_d = S_CHK0;
        end
      end
      S_CHK0: begin
        cmd.addr_sel = ADDR_LAST;
        if (sts_i.le_first) begin
          cmd.res_load = 1'b1;
          cmd.res_how  = HOW_CLAMP_LO;
          state_d      = S_OUT;
        end else begin
          state_d = S_CHKN;
        end
      end
      S_CHKN: begin
        if (sts_i.ge_last) begin
          cmd.res_load = 1'b1;
          cmd.res_how  = HOW_CLAMP_HI;
          state_d      = S_OUT;
        end else begin
          cmd.search_init = 1'b1;
          state_d         = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.addr_sel = ADDR_MID;
        state_d      = sts_i.search_end ? S_RDUP : S_CMP;
      end
      S_CMP: begin
        if (sts_i.cmp_gt || sts_i.cmp_lt) begin
          cmd.search_step = 1'b1;
          state_d         = S_PROBE;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_how  = HOW_EXACT;
          state_d      = S_OUT;
        end
      end
      S_RDUP: begin
        cmd.addr_sel = ADDR_UP;
        state_d      = S_RDDN;
      end
      S_RDDN: begin
        cmd.addr_sel = ADDR_DN;
        cmd.cap_up   = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd.cap_dn = 1'b1;
        state_d    = S_CHKDV;
      end
      S_CHKDV: begin
        if (sts_i.dv_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_BASE;
          cmd.res_how  = HOW_INTERP;
          state_d      = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_SUM;
        cmd.res_how  = HOW_INTERP;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // The result moves on once the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: sv/thermistor_table_interpolator_unit.sv
// Top level of the thermistor table interpolator; joins controller and datapath.
// Depends on tti_pkg, tti_if, tti_ctrl and tti_dp.
//
// Converts ADC readings to temperatures (tenths of a degree) from a table of
// ascending ADC/temperature pairs held in a memory with one write port and a
// registered read port. A write item loads one entry and leaves the block
// ready for the next item. A convert item is handled one at a time: an empty
// table answers with the fallback temperature, a reading at or beyond the
// first or last entry is clamped to that entry, and an exact hit is found by
// a binary search that reads one entry per probe. An interpolated result
// further needs one closing probe, neighbor reads, multiply and divisor
// check, a restoring divider that retires one quotient bit per cycle over a
// dividend of 16 + ADC_BITS bits (capped at 32) and a final add and
// saturate. A finished result waits in an output register while the next
// item is taken in.
module thermistor_table_interpolator_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADC_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tti_cfg_if.sink    cfg_i,
  tti_in_if.sink     in_i,
  tti_out_if.source  out_o
);

  import tti_pkg::*;

  tti_cmd_t cmd;
  tti_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  tti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  tti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADC_BITS    (ADC_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_i.valid),
    .cfg_data_i          (cfg_i.entry_count),
    .entry_index_i       (in_i.entry_index),
    .entry_adc_i         (in_i.entry_adc),
    .entry_temperature_i (in_i.entry_temperature),
    .reading_i           (in_i.reading),
    .temperature_o       (out_o.temperature),
    .found_how_o         (out_o.found_how)
  );

  // The count register takes a transfer in any cycle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

FILE: verif/thermistor_table_interpolator_unit_tb.sv
// Self-checking testbench of thermistor_table_interpolator_unit: loads tables, converts readings
// and compares every result with a predictor kept inside this file.
// Depends on tti_pkg and the tti_in_if, tti_out_if and tti_cfg_if interfaces.
module thermistor_table_interpolator_unit_tb;
  import tti_pkg::*;

  localparam int DEPTH         = 64;
  localparam int RANDOM_ITEMS  = 720;
  localparam int DRAIN_SLACK   = 80;
  localparam int MAX_PRINTED   = 40;
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CONVERT  = 1'b1;

  typedef enum int {SHAPE_SORTED, SHAPE_DUPS, SHAPE_SHUFFLED} table_shape_e;

  typedef struct packed {
    logic                      op;
    logic [IDX_IN_W-1:0]       index;
    logic [IN_ADC_W-1:0]       adc;
    logic signed [TEMP_W-1:0]  temp;
    logic [IN_ADC_W-1:0]       reading;
  } table_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    found_how_e               how;
  } temp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tti_cfg_if cfg_bus ();
  tti_in_if  in_bus ();
  tti_out_if out_bus ();

  thermistor_table_interpolator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: the table as the block should hold it and the entry_count register.
  logic [IN_ADC_W-1:0]      tbl_adc [DEPTH];
  logic signed [TEMP_W-1:0] tbl_temp [DEPTH];
  logic [COUNT_W-1:0]       tbl_count;
  temp_result_t             pending_temps[$];

  int errors;
  int n_writes;
  int n_converts;
  int n_results;
  int n_settings;
  int send_idle_pct;
  int recv_stall_pct;
  bit offering;
  int hold_len;
  int hold_req;
  int hold_ack;
  int hold_left;

  function automatic temp_result_t convert_reading(input logic [IN_ADC_W-1:0] rd);
    int n, lo, hi, mid, up, dn;
    longint base, dv, t;
    bit hit;
    temp_result_t r;
    n = (tbl_count > DEPTH) ? DEPTH : int'(tbl_count);
    hit = 1'b0;
    if (n == 0) begin
      r.temperature = FALLBACK_TEMP;
      r.how = HOW_FALLBACK;
    end else if (tbl_adc[0] >= rd) begin
      r.temperature = tbl_temp[0];
      r.how = HOW_CLAMP_LO;
    end else if (tbl_adc[n-1] <= rd) begin
      r.temperature = tbl_temp[n-1];
      r.how = HOW_CLAMP_HI;
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        if (tbl_adc[mid] > rd) begin
          hi = mid - 1;
        end else if (tbl_adc[mid] < rd) begin
          lo = mid + 1;
        end else begin
          hit = 1'b1;
          r.temperature = tbl_temp[mid];
          r.how = HOW_EXACT;
        end
      end
      if (!hit) begin
        // Neighbors that fall outside the valid entries snap to the nearest edge.
        up = (lo > n - 1) ? n - 1 : (lo < 0 ? 0 : lo);
        dn = (hi > n - 1) ? n - 1 : (hi < 0 ? 0 : hi);
        base = longint'(tbl_temp[dn]);
        dv = longint'(tbl_adc[up]) - longint'(tbl_adc[dn]);
        if (dv == 0) begin
          t = base;
        end else begin
          t = base + ((longint'(tbl_temp[up]) - base) *
                      (longint'(rd) - longint'(tbl_adc[dn]))) / dv;
        end
        if (t > 32767) t = 32767;
        else if (t < -32768) t = -32768;
        r.temperature = t[TEMP_W-1:0];
        r.how = HOW_INTERP;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Result checker: every transfer on the output channel is matched against the oldest prediction.
  always @(posedge clk_i) begin
    temp_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_temps.size() == 0) begin
        report_mismatch($sformatf("unexpected result temperature %0d found_how %0d",
                                  out_bus.temperature, out_bus.found_how));
      end else begin
        want = pending_temps.pop_front();
        n_results++;
        if (out_bus.temperature !== want.temperature)
          report_mismatch($sformatf("temperature %0d, predicted %0d",
                                    out_bus.temperature, want.temperature));
        if (out_bus.found_how !== want.how)
          report_mismatch($sformatf("found_how %0d, predicted %0d",
                                    out_bus.found_how, want.how));
      end
    end
  end

  // Result ready. A requested hold-off keeps ready low while its countdown from hold_len runs.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  task automatic send_item(input table_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid <= 1'b1;
    offering = 1'b1;
    in_bus.op <= it.op;
    in_bus.entry_index <= it.index;
    in_bus.entry_adc <= it.adc;
    in_bus.entry_temperature <= it.temp;
    in_bus.reading <= it.reading;
    do @(posedge clk_i); while (!in_bus.ready);
    if (it.op == OP_WRITE) begin
      tbl_adc[it.index] = it.adc;
      tbl_temp[it.index] = it.temp;
      n_writes++;
    end else begin
      pending_temps.push_back(convert_reading(it.reading));
      n_converts++;
    end
  endtask

  // Unused fields of each item carry random values.
  task automatic send_write(input int idx, input logic [IN_ADC_W-1:0] adc,
                            input logic [TEMP_W-1:0] temp);
    table_item_t it;
    it.op = OP_WRITE;
    it.index = idx[IDX_IN_W-1:0];
    it.adc = adc;
    it.temp = temp;
    it.reading = IN_ADC_W'($urandom);
    send_item(it);
  endtask

  task automatic send_convert(input logic [IN_ADC_W-1:0] rd);
    table_item_t it;
    it.op = OP_CONVERT;
    it.index = IDX_IN_W'($urandom);
    it.adc = IN_ADC_W'($urandom);
    it.temp = TEMP_W'($urandom);
    it.reading = rd;
    send_item(it);
  endtask

  // Stops offering, waits for every predicted result, then lets a write item still in the
  // block finish before anything else happens.
  task automatic wait_drained();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_temps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.entry_count <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tbl_count = value;
    n_settings++;
  endtask

  function automatic logic [IN_ADC_W-1:0] pick_reading(input int n_eff);
    int sel, i;
    if (n_eff == 0) return IN_ADC_W'($urandom);
    sel = $urandom_range(99);
    i = $urandom_range(n_eff - 1);
    if (sel < 35) return tbl_adc[i];
    if (sel < 70 && n_eff > 1) begin
      i = $urandom_range(n_eff - 2);
      if (tbl_adc[i+1] > tbl_adc[i] + 1)
        return IN_ADC_W'($urandom_range(tbl_adc[i+1] - 1, tbl_adc[i] + 1));
      return IN_ADC_W'($urandom);
    end
    if (sel < 80) return IN_ADC_W'($urandom_range(tbl_adc[0]));
    if (sel < 90) return IN_ADC_W'($urandom_range(16'hFFFF, tbl_adc[n_eff-1]));
    return IN_ADC_W'($urandom);
  endfunction

  // Sets entry_count, fills every entry it covers, then converts readings around the table.
  // A few temperature rewrites are mixed in between conversions.
  task automatic run_phase(input int count_val, input table_shape_e shape, input int n_conv);
    int n_eff, step_max, v, i, k;
    logic [IN_ADC_W-1:0] a;
    n_eff = (count_val > DEPTH) ? DEPTH : count_val;
    write_entry_count(count_val[COUNT_W-1:0]);
    v = ($urandom_range(3) == 0) ? 0 : $urandom_range(4000);
    step_max = (n_eff > 1) ? (65535 - v) / (n_eff - 1) : 1;
    for (i = 0; i < n_eff; i++) begin
      if (shape == SHAPE_SHUFFLED) begin
        a = IN_ADC_W'($urandom);
      end else begin
        a = v[IN_ADC_W-1:0];
        if (shape != SHAPE_DUPS || $urandom_range(2) != 0) v += $urandom_range(step_max, 1);
      end
      send_write(i, a, TEMP_W'($urandom));
    end
    for (k = 0; k < n_conv; k++) begin
      if (n_eff > 0 && $urandom_range(99) < 8) begin
        i = $urandom_range(n_eff - 1);
        send_write(i, tbl_adc[i], TEMP_W'($urandom));
      end else begin
        send_convert(pick_reading(n_eff));
      end
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_convert(16'h0000);
    send_convert(16'hFFFF);
    send_write(0, 16'd100, 16'sh8000);
    send_write(1, 16'd200, -16'sd1);
    send_write(2, 16'd300, 16'sh7FFF);
    send_write(3, 16'hFFFF, 16'sd0);
    send_write(63, 16'h0000, 16'sh7FFF);
    // Single entry: at or below it clamps low, anything above clamps high.
    write_entry_count(7'd1);
    send_convert(16'd100);
    send_convert(16'd101);
    send_convert(16'd0);
    write_entry_count(7'd4);
    send_convert(16'd0);
    send_convert(16'hFFFF);
    send_convert(16'd200);
    send_convert(16'd150);
    send_convert(16'd250);
    send_convert(16'd300);
    send_convert(16'd40000);
    // Two entries with the same ADC value, then one that breaks the ascending order.
    send_write(1, 16'd300, 16'sd5000);
    send_convert(16'd250);
    send_convert(16'd300);
    send_write(1, 16'hF000, -16'sd20000);
    send_convert(16'd1000);
    send_convert(16'd60000);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    // Earlier results must be gone before the hold-off starts, so that it catches this phase.
    wait_drained();
    hold_len = 800;
    hold_req++;
    run_phase(DEPTH, SHAPE_SORTED, 40);
    // The sender now pauses until every outstanding result has been taken.
    wait_drained();
  endtask

  task automatic test_count_overflow();
    set_idling(18, 18);
    run_phase(127, SHAPE_SORTED, 30);
    run_phase(65, SHAPE_DUPS, 20);
  endtask

  task automatic test_random_tables();
    int goal, phase, cnt, pick;
    table_shape_e shape;
    goal = n_writes + n_converts + RANDOM_ITEMS;
    phase = 0;
    while (n_writes + n_converts < goal) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(63, 0);
        2: set_idling(0, 63);
        default: set_idling(18, 18);
      endcase
      pick = $urandom_range(9);
      case (pick)
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 2;
        3: cnt = DEPTH;
        4: cnt = $urandom_range(127, DEPTH + 1);
        default: cnt = $urandom_range(16, 3);
      endcase
      pick = $urandom_range(9);
      if (pick < 6) shape = SHAPE_SORTED;
      else if (pick < 8) shape = SHAPE_DUPS;
      else shape = SHAPE_SHUFFLED;
      run_phase(cnt, shape, $urandom_range(60, 20));
      phase++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.entry_count = '0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_WRITE;
    in_bus.entry_index = '0;
    in_bus.entry_adc = '0;
    in_bus.entry_temperature = '0;
    in_bus.reading = '0;
    out_bus.ready = 1'b0;
    tbl_count = '0;
    offering = 1'b0;
    set_idling(0, 0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_count_overflow();
    test_random_tables();
    wait_drained();
    $display("Checked %0d of %0d conversions; %0d table writes over %0d entry_count settings.",
             n_results, n_converts, n_writes, n_settings);
    $display("Tables were sorted, with repeated ADC values or out of order, under four idling mixes.");
    if (errors == 0) begin
      $display("thermistor_table_interpolator_unit_tb OK");
    end else begin
      $display("thermistor_table_interpolator_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("Timeout with %0d results still outstanding.", pending_temps.size());
    $display("thermistor_table_interpolator_unit_tb NOT OK");
    $finish;
  end

endmodule
